// ===== hw/rtl/ssmpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmpd_pkg
// Shared types, opcodes, glyph codes and lookup functions for the
// multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
package ssmpd_pkg;

    typedef logic [1:0] t_opcode;
    typedef logic [5:0] t_glyph;
    typedef logic [7:0] t_segs;

    localparam t_opcode OP_TICK  = 2'd0;
    localparam t_opcode OP_SET   = 2'd1;
    localparam t_opcode OP_NUMBER = 2'd2;
    localparam t_opcode OP_CLEAR = 2'd3;

    localparam t_glyph GLYPH_DASH  = 6'd36;
    localparam t_glyph GLYPH_POINT = 6'd37;
    localparam t_glyph GLYPH_BLANK = 6'd38;

    localparam int BRIGHT_W = 7;

    // ceil(2^32 / 10^i); exact quotient for any 16-bit dividend
    localparam int MAX_DEC_DIGITS = 5;
    localparam logic [31:0] POW10_RECIP [0:4] = '{
        32'd0, 32'd429496730, 32'd42949673, 32'd4294968, 32'd429497
    };

    function automatic t_glyph char_to_glyph(input logic [7:0] c);
        t_glyph g;
        g = GLYPH_BLANK;
        if (c inside {[8'h30:8'h39]}) begin
            g = 6'(c - 8'h30);
        end else if (c inside {[8'h41:8'h5A]}) begin
            g = 6'(c - 8'h37);
        end else if (c == 8'h2D) begin
            g = GLYPH_DASH;
        end else if (c == 8'h2E) begin
            g = GLYPH_POINT;
        end
        return g;
    endfunction

    function automatic t_segs glyph_to_segs(input t_glyph g);
        t_segs s;
        case (g)
            6'd0:  s = 8'h3F;
            6'd1:  s = 8'h06;
            6'd2:  s = 8'h5B;
            6'd3:  s = 8'h4F;
            6'd4:  s = 8'h66;
            6'd5:  s = 8'h6D;
            6'd6:  s = 8'h7D;
            6'd7:  s = 8'h07;
            6'd8:  s = 8'h7F;
            6'd9:  s = 8'h6F;
            6'd10: s = 8'h37;
            6'd11: s = 8'h79;
            6'd12: s = 8'h39;
            6'd13: s = 8'h5E;
            6'd14: s = 8'h79;
            6'd15: s = 8'h71;
            6'd16: s = 8'h7C;
            6'd17: s = 8'h37;
            6'd18: s = 8'h06;
            6'd19: s = 8'h1E;
            6'd20: s = 8'h70;
            6'd21: s = 8'h38;
            6'd22: s = 8'h15;
            6'd23: s = 8'h37;
            6'd24: s = 8'h3F;
            6'd25: s = 8'h73;
            6'd26: s = 8'h67;
            6'd27: s = 8'h31;
            6'd28: s = 8'h6D;
            6'd29: s = 8'h78;
            6'd30: s = 8'h3E;
            6'd31: s = 8'h3E;
            6'd32: s = 8'h2A;
            6'd33: s = 8'h76;
            6'd34: s = 8'h6E;
            6'd35: s = 8'h5B;
            6'd36: s = 8'h40;
            6'd37: s = 8'h80;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// ===== hw/rtl/ssmpd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmpd_if
// Valid/ready channels of the display driver: command items, tick results
// and the brightness write port.
// ----------------------------------------------------------------------------
interface ssmpd_in_if;
    logic                 valid;
    logic                 ready;
    ssmpd_pkg::t_opcode   opcode;
    logic [1:0]           digit_pos;
    logic [7:0]           char_code;
    logic [15:0]          number;

    modport source (output valid, opcode, digit_pos, char_code, number, input ready);
    modport sink   (input valid, opcode, digit_pos, char_code, number, output ready);
endinterface

interface ssmpd_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        digit_select;
    ssmpd_pkg::t_segs  segment_bits;

    modport source (output valid, digit_select, segment_bits, input ready);
    modport sink   (input valid, digit_select, segment_bits, output ready);
endinterface

interface ssmpd_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] brightness;

    modport source (output valid, brightness, input ready);
    modport sink   (input valid, brightness, output ready);
endinterface

// ===== hw/rtl/ssmpd_bcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmpd_bcd
// Splits a 16-bit number into its low decimal digits as glyph codes.
// ----------------------------------------------------------------------------
module ssmpd_bcd #(
    parameter int NUM_DIGITS = 4
) (
    input  logic [15:0]       i_number,
    output ssmpd_pkg::t_glyph o_glyph [NUM_DIGITS]
);
    import ssmpd_pkg::*;

    // q[i] = number / 10^i, by reciprocal multiply; zero past five digits
    logic [15:0] q [NUM_DIGITS+1];

    genvar g;
    generate
        for (g = 0; g <= NUM_DIGITS; g++) begin : g_quot
            if (g == 0) begin : g_id
                assign q[g] = i_number;
            end else if (g < MAX_DEC_DIGITS) begin : g_mul
                logic [47:0] prod;
                assign prod = 48'(i_number) * 48'(POW10_RECIP[g]);
                assign q[g] = prod[47:32];
            end else begin : g_zero
                assign q[g] = '0;
            end
        end

        for (g = 0; g < NUM_DIGITS; g++) begin : g_digit
            logic [15:0] rem;
            assign rem = q[g] - ((q[g+1] << 3) + (q[g+1] << 1));
            assign o_glyph[g] = {2'b00, rem[3:0]};
        end
    endgenerate

endmodule

// ===== hw/rtl/ssmpd_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssmpd_scan
// PWM phase counter, digit scan counter and blanking compare.
// ----------------------------------------------------------------------------
module ssmpd_scan #(
    parameter int NUM_DIGITS     = 4,
    parameter int MAX_BRIGHTNESS = 100
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [6:0]                    i_brightness,
    output logic [$clog2(NUM_DIGITS)-1:0] o_scan_idx,
    output logic                          o_blank
);
    import ssmpd_pkg::*;

    localparam int IW    = $clog2(NUM_DIGITS);
    localparam int PW    = $clog2(MAX_BRIGHTNESS);
    localparam int CMP_W = (PW > BRIGHT_W) ? PW : BRIGHT_W;

    localparam logic [IW-1:0] SCAN_LAST  = IW'(NUM_DIGITS - 1);
    localparam logic [PW-1:0] PHASE_LAST = PW'(MAX_BRIGHTNESS - 1);

    logic [IW-1:0] r_scan, n_scan;
    logic [PW-1:0] r_phase, n_phase;

    always_comb begin
        n_scan  = r_scan;
        n_phase = r_phase;
        if (i_tick) begin
            if (r_phase == '0) begin
                n_scan = (r_scan == SCAN_LAST) ? '0 : r_scan + 1'b1;
            end
            n_phase = (r_phase == PHASE_LAST) ? '0 : r_phase + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan  <= '0;
            r_phase <= '0;
        end else begin
            r_scan  <= n_scan;
            r_phase <= n_phase;
        end
    end

    assign o_scan_idx = r_scan;
    assign o_blank    = CMP_W'(r_phase) > CMP_W'(i_brightness);

endmodule

// ===== hw/rtl/seven_segment_mux_pwm_driver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_mux_pwm_driver_unit
// Multiplexed seven-segment display driver with PWM dimming.
// ----------------------------------------------------------------------------
// The block takes one command item per clock: tick, set a digit from an ASCII
// character, write a decimal number, or clear all digits. Each item is held
// in an input register and executed from there; a tick's result is written
// into the output register by the same edge that executes the tick. Every
// command item is taken back to back at one per cycle; the only stall is a
// tick sitting in the input register while the output register still holds
// an untaken result. Non-tick commands produce no result. Segments are blanked
// when the PWM phase (ticks mod MAX_BRIGHTNESS) exceeds brightness, and the
// scan moves to the next digit on each tick whose phase is zero. The
// brightness port is always ready; writes saturate at MAX_BRIGHTNESS and
// should only be issued while the block is idle.
// ----------------------------------------------------------------------------
module seven_segment_mux_pwm_driver_unit #(
    parameter int NUM_DIGITS     = 4,
    parameter int MAX_BRIGHTNESS = 100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssmpd_in_if.sink    i_item,
    ssmpd_out_if.source o_result,
    ssmpd_cfg_if.sink   i_cfg
);
    import ssmpd_pkg::*;

    localparam int IW = $clog2(NUM_DIGITS);
    localparam logic [BRIGHT_W-1:0] BRIGHT_RST =
        BRIGHT_W'((MAX_BRIGHTNESS < 50) ? MAX_BRIGHTNESS : 50);

    // ---- brightness register ----
    logic [BRIGHT_W-1:0] r_bright, n_bright;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_bright = r_bright;
        if (i_cfg.valid) begin
            // clamp only bites when MAX_BRIGHTNESS is below the 7-bit range
            n_bright = (int'(i_cfg.brightness) > MAX_BRIGHTNESS) ?
                       BRIGHT_W'(MAX_BRIGHTNESS) : i_cfg.brightness;
        end
    end

    // ---- input register ----
    logic        r_in_valid;
    t_opcode     r_opcode;
    logic [1:0]  r_pos;
    logic [7:0]  r_char;
    logic [15:0] r_num;

    logic w_out_free;   // output register can take a new result this edge
    logic w_adv;        // item in the input register executes this edge
    logic w_tick;       // ... and it is a tick

    assign w_out_free   = !o_result.valid || o_result.ready;
    assign w_adv        = r_in_valid && ((r_opcode != OP_TICK) || w_out_free);
    assign w_tick       = w_adv && (r_opcode == OP_TICK);
    assign i_item.ready = !r_in_valid || w_adv;

    // ---- scan / PWM counters ----
    logic [IW-1:0] w_scan_idx;
    logic          w_blank;

    ssmpd_scan #(
        .NUM_DIGITS     (NUM_DIGITS),
        .MAX_BRIGHTNESS (MAX_BRIGHTNESS)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_brightness (r_bright),
        .o_scan_idx   (w_scan_idx),
        .o_blank      (w_blank)
    );

    // ---- number to glyphs ----
    t_glyph w_num_glyph [NUM_DIGITS];

    ssmpd_bcd #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_bcd (
        .i_number (r_num),
        .o_glyph  (w_num_glyph)
    );

    // ---- glyph buffer ----
    t_glyph r_glyph [NUM_DIGITS];
    t_glyph n_glyph [NUM_DIGITS];
    t_glyph w_char_glyph;

    assign w_char_glyph = char_to_glyph(r_char);

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            n_glyph[i] = r_glyph[i];
            if (w_adv) begin
                case (r_opcode)
                    OP_SET: begin
                        // positions past the last digit never match
                        if (int'(r_pos) == i) begin
                            n_glyph[i] = w_char_glyph;
                        end
                    end
                    OP_NUMBER: begin
                        n_glyph[i] = w_num_glyph[i];
                    end
                    OP_CLEAR: begin
                        n_glyph[i] = GLYPH_BLANK;
                    end
                    default: begin
                        n_glyph[i] = r_glyph[i];
                    end
                endcase
            end
        end
    end

    // ---- output register ----
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_dsel, n_dsel;
    t_segs      r_seg, n_seg;

    always_comb begin
        n_out_valid = r_out_valid;
        n_dsel      = r_dsel;
        n_seg       = r_seg;
        if (o_result.valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_tick) begin
            n_out_valid = 1'b1;
            // only the low two bits of the scan index reach the pins
            n_dsel      = 2'(w_scan_idx);
            n_seg       = w_blank ? '0 : glyph_to_segs(r_glyph[w_scan_idx]);
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.digit_select = r_dsel;
    assign o_result.segment_bits = r_seg;

    // ---- registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_bright    <= BRIGHT_RST;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                r_glyph[i] <= GLYPH_BLANK;
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_bright    <= n_bright;
            r_glyph     <= n_glyph;
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_dsel <= n_dsel;
        r_seg  <= n_seg;
        if (i_item.ready && i_item.valid) begin
            r_opcode <= i_item.opcode;
            r_pos    <= i_item.digit_pos;
            r_char   <= i_item.char_code;
            r_num    <= i_item.number;
        end
    end

    // ---- assertions ----
    // an executed tick always leaves a result in the output register
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick |=> r_out_valid)
        else $error("tick executed without a result");

    // a blanked tick drives no segments
    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick && w_blank) |=> (r_seg == '0))
        else $error("blanked tick produced segments");

    // a tick waiting on a full output stage is held, not dropped
    a_tick_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_opcode == OP_TICK) && r_out_valid && !o_result.ready)
        |=> (r_in_valid && (r_opcode == OP_TICK) && $stable(r_num)))
        else $error("stalled tick lost");

endmodule

// ===== tb/seven_segment_mux_pwm_driver_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_mux_pwm_driver_unit_test
// Self-checking bench for the multiplexed seven-segment display driver.
// ----------------------------------------------------------------------------
// Command items go in over the valid/ready input channel. A scoreboard keeps
// its own glyph buffer, scan position, tick counter and brightness. It works
// out the frame each tick should drive and compares every result frame with
// the oldest one still due. The run covers a directed opening, then random
// phases at several brightness levels (zero, full, clamped and random). Both
// handshake sides idle in random bursts, and one long output hold-off fills
// the block. The last phase runs with no idling.
// ----------------------------------------------------------------------------
module seven_segment_mux_pwm_driver_unit_test;
    import ssmpd_pkg::*;

    localparam int NUM_DIGITS     = 4;
    localparam int MAX_BRIGHT     = 100;
    localparam int RESET_BRIGHT   = 50;
    localparam int SETTLE_CYCLES  = 6;      // covers the two-stage pipeline
    localparam int HOLD_CYCLES    = 300;    // long output hold-off
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 240;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    typedef struct {
        t_opcode     op;
        logic [1:0]  pos;
        logic [7:0]  ch;
        logic [15:0] num;
    } cmd_t;

    typedef struct {
        logic [1:0] sel;
        t_segs      segs;
    } frame_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the display state and holds the frames still due.
    // ------------------------------------------------------------------------
    class scan_tracker;
        t_glyph     glyphs [NUM_DIGITS];
        logic [7:0] seg_rom [39];
        int         scan;
        int         ticks;
        int         level;
        frame_t     frames_due [$];
        int         faults;

        function new();
            seg_rom = '{
                8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
                8'h37, 8'h79, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h7C, 8'h37, 8'h06, 8'h1E,
                8'h70, 8'h38, 8'h15, 8'h37, 8'h3F, 8'h73, 8'h67, 8'h31, 8'h6D, 8'h78,
                8'h3E, 8'h3E, 8'h2A, 8'h76, 8'h6E, 8'h5B,
                8'h40, 8'h80, 8'h00
            };
            foreach (glyphs[i]) glyphs[i] = GLYPH_BLANK;
            scan   = 0;
            ticks  = 0;
            level  = RESET_BRIGHT;
            faults = 0;
        endfunction

        function t_glyph ascii_glyph(logic [7:0] c);
            if (c >= "0" && c <= "9") return t_glyph'(c - "0");
            if (c >= "A" && c <= "Z") return t_glyph'(c - "A" + 10);
            if (c == "-") return GLYPH_DASH;
            if (c == ".") return GLYPH_POINT;
            return GLYPH_BLANK;
        endfunction

        function void set_brightness(logic [6:0] v);
            level = (int'(v) > MAX_BRIGHT) ? MAX_BRIGHT : int'(v);
        endfunction

        function void note_command(cmd_t c);
            frame_t f;
            int     phase;
            int     rest;
            case (c.op)
                OP_TICK: begin
                    phase  = ticks % MAX_BRIGHT;
                    f.sel  = 2'(scan);
                    f.segs = (phase > level) ? 8'h00 : seg_rom[glyphs[scan]];
                    frames_due.push_back(f);
                    if (phase == 0) scan = (scan + 1) % NUM_DIGITS;
                    ticks = (ticks + 1) % (MAX_BRIGHT * 4);
                end
                OP_SET: begin
                    glyphs[c.pos] = ascii_glyph(c.ch);
                end
                OP_NUMBER: begin
                    rest = c.num;
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        glyphs[i] = t_glyph'(rest % 10);
                        rest = rest / 10;
                    end
                end
                default: begin
                    foreach (glyphs[i]) glyphs[i] = GLYPH_BLANK;
                end
            endcase
        endfunction

        function void check_result(logic [1:0] sel, t_segs segs);
            frame_t f;
            if (frames_due.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected frame: select %0d segments %h", sel, segs);
                return;
            end
            f = frames_due.pop_front();
            if (sel !== f.sel || segs !== f.segs) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("frame mismatch: expected select %0d segments %h, got %0d %h",
                             f.sel, f.segs, sel, segs);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    ssmpd_in_if  item_if ();
    ssmpd_out_if res_if ();
    ssmpd_cfg_if cfg_if ();

    seven_segment_mux_pwm_driver_unit #(
        .NUM_DIGITS     (NUM_DIGITS),
        .MAX_BRIGHTNESS (MAX_BRIGHT)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    scan_tracker sb;
    bit          quiet;       // no idling on either side
    bit          hold_req;    // ask the result side for a long hold-off
    bit          rst_done;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Every block input gets a known value before the first edge.
    initial begin
        i_rst_n           <= 1'b0;
        item_if.valid     <= 1'b0;
        item_if.opcode    <= OP_TICK;
        item_if.digit_pos <= '0;
        item_if.char_code <= '0;
        item_if.number    <= '0;
        res_if.ready      <= 1'b0;
        cfg_if.valid      <= 1'b0;
        cfg_if.brightness <= '0;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each taken frame, then pick ready for the next edge.
    // The long hold-off is counted here so the sender keeps pushing ticks
    // until the block backs up its input.
    // ------------------------------------------------------------------------
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        wait (rst_done);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.digit_select, res_if.segment_bits);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 14);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks (called at a rising edge)
    // ------------------------------------------------------------------------
    task automatic send_cmd(cmd_t c);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.opcode    <= c.op;
        item_if.digit_pos <= c.pos;
        item_if.char_code <= c.ch;
        item_if.number    <= c.num;
        do @(posedge i_clk); while (!(item_if.valid && item_if.ready));
        sb.note_command(c);
    endtask

    task automatic send_op(t_opcode op, logic [1:0] pos, logic [7:0] ch, logic [15:0] num);
        cmd_t c;
        c.op  = op;
        c.pos = pos;
        c.ch  = ch;
        c.num = num;
        send_cmd(c);
    endtask

    // Brightness is only written with nothing in flight.
    task automatic write_brightness(logic [6:0] v);
        cfg_if.valid      <= 1'b1;
        cfg_if.brightness <= v;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        sb.set_brightness(v);
        cfg_if.valid <= 1'b0;
    endtask

    // Stop offering items, wait for every due frame, then let a
    // set/number/clear still in the pipeline finish.
    task automatic settle();
        item_if.valid <= 1'b0;
        while (sb.frames_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly ticks so the PWM phase and scan sweep wide; the rest edit the
    // buffer with a mix of valid glyph characters and raw bytes.
    task automatic run_random(int n);
        string glyph_chars;
        cmd_t  c;
        int    pick;
        glyph_chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-.";
        for (int i = 0; i < n; i++) begin
            pick  = $urandom_range(0, 99);
            c.pos = 2'($urandom);
            c.ch  = 8'($urandom);
            c.num = 16'($urandom);
            if (pick < 70) begin
                c.op = OP_TICK;
            end else if (pick < 85) begin
                c.op = OP_SET;
                if ($urandom_range(0, 1) == 0)
                    c.ch = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
            end else if (pick < 93) begin
                c.op = OP_NUMBER;
                if ($urandom_range(0, 1) == 0) c.num = 16'($urandom_range(0, 9999));
            end else begin
                c.op = OP_CLEAR;
            end
            send_cmd(c);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [6:0] levels [6];
        sb       = new();
        quiet    = 1'b0;
        hold_req = 1'b0;
        rst_done = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        // Directed opening at the reset brightness: blank after reset,
        // glyph extremes, lowercase and high codes, number extremes, clear.
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_SET,    2'd0, "0",   16'h0000);
        send_op(OP_SET,    2'd1, "9",   16'hFFFF);
        send_op(OP_SET,    2'd2, "A",   16'h0000);
        send_op(OP_SET,    2'd3, "Z",   16'hFFFF);
        send_op(OP_TICK,   2'd3, 8'hFF, 16'hFFFF);
        send_op(OP_SET,    2'd0, "-",   16'h0000);
        send_op(OP_SET,    2'd1, ".",   16'h0000);
        send_op(OP_SET,    2'd2, "a",   16'h0000);
        send_op(OP_SET,    2'd3, 8'hFF, 16'h0000);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_SET,    2'd0, 8'h00, 16'h0000);
        send_op(OP_SET,    2'd1, 8'h80, 16'h0000);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_NUMBER, 2'd0, 8'h00, 16'hFFFF);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_NUMBER, 2'd3, 8'hFF, 16'd0);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_NUMBER, 2'd0, 8'h00, 16'd1234);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);
        send_op(OP_CLEAR,  2'd2, 8'h41, 16'h5555);
        send_op(OP_TICK,   2'd1, 8'h00, 16'hAAAA);
        send_op(OP_SET,    2'd3, "7",   16'h1234);
        send_op(OP_TICK,   2'd0, 8'h00, 16'h0000);

        run_random(PHASE_ITEMS + 10);

        // Zero, full, clamped, and random levels.
        levels[0] = 7'd0;
        levels[1] = 7'(MAX_BRIGHT);
        levels[2] = 7'd127;
        levels[3] = 7'($urandom_range(1, MAX_BRIGHT - 1));
        levels[4] = 7'($urandom_range(MAX_BRIGHT + 1, 127));
        levels[5] = 7'($urandom_range(0, 127));

        foreach (levels[k]) begin
            settle();
            write_brightness(levels[k]);
            if (k == 2) hold_req = 1'b1;
            if (k == 5) quiet = 1'b1;
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.faults += sb.frames_due.size();
        if (sb.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
